// File: src/obb_pkg.sv
// obb_pkg: shared constants and types for the per-second ohlc bar builder
// used by obb_sec_div, obb_ram and per_second_ohlc_bar_builder
package obb_pkg;

    localparam int BOOK_LEVELS_DEF = 3;

    localparam int SERIES_W = 3;
    localparam int TS_W     = 64;
    localparam int PRICE_W  = 64;
    localparam int QTY_W    = 32;
    localparam int SEC_W    = 35;

    // 1e9 = 2^9 * 5^9: shift off the power of two, divide the rest by 5^9
    localparam int TS_SHIFT = 9;
    localparam int X_W      = TS_W - TS_SHIFT;
    localparam int DIV_W    = 21;
    localparam logic [DIV_W-1:0] SEC_DIV = DIV_W'(1953125);
    localparam logic [63:0] SEC_RECIP64 = (64'd1 << X_W) / 64'd1953125;
    localparam logic [SEC_W-1:0] SEC_RECIP = SEC_RECIP64[SEC_W-1:0];
    localparam int LIMB_W   = 28;
    localparam int PROD_W   = X_W + SEC_W;

    // register stages inside the second divider
    localparam int DIV_LAT  = 4;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_FLUSH  = 1'b1;

    typedef struct packed {
        logic                      op;
        logic [SERIES_W-1:0]       series;
        logic                      in_range;
        logic                      sample_ok;
        logic signed [PRICE_W-1:0] price;
    } t_item;

    typedef struct packed {
        logic [SEC_W-1:0]          start;
        logic signed [PRICE_W-1:0] open_p;
        logic signed [PRICE_W-1:0] high_p;
        logic signed [PRICE_W-1:0] low_p;
        logic signed [PRICE_W-1:0] close_p;
    } t_bar;

    localparam int BAR_W = $bits(t_bar);

endpackage

// File: src/obb_ram.sv
// obb_ram: generic single write port, single read port ram
// registered read with read enable, old data on a same-address write; uses obb_pkg defaults
module obb_ram #(
    parameter int WIDTH = obb_pkg::BAR_W,
    parameter int DEPTH = 2 * obb_pkg::BOOK_LEVELS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: src/obb_sec_div.sv
// obb_sec_div: pipelined divide of a shifted nanosecond count by 5^9
// reciprocal multiply in 28-bit limbs, then one correction step; uses obb_pkg
module obb_sec_div (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [obb_pkg::X_W-1:0]   i_x,
    output logic [obb_pkg::SEC_W-1:0] o_sec
);
    import obb_pkg::*;

    localparam int X1_W = X_W - LIMB_W;
    localparam int M1_W = SEC_W - LIMB_W;
    localparam int RP_W = SEC_W + DIV_W;

    logic [X1_W-1:0]   x1;
    logic [LIMB_W-1:0] x0;
    logic [M1_W-1:0]   m1;
    logic [LIMB_W-1:0] m0;

    logic [X1_W+M1_W-1:0]     r_b_p11;
    logic [X1_W+LIMB_W-1:0]   r_b_p10;
    logic [LIMB_W+M1_W-1:0]   r_b_p01;
    logic [2*LIMB_W-1:0]      r_b_p00;
    logic [X_W-1:0]           r_b_x;

    logic [PROD_W-1:0]        n_c_sum;
    logic [SEC_W-1:0]         r_c_q;
    logic [X_W-1:0]           r_c_x;

    logic [RP_W-1:0]          r_d_prod;
    logic [SEC_W-1:0]         r_d_q;
    logic [X_W-1:0]           r_d_x;

    logic [X_W-1:0]           n_e_rem;
    logic [SEC_W-1:0]         r_e_sec;

    assign x1 = i_x[X_W-1:LIMB_W];
    assign x0 = i_x[LIMB_W-1:0];
    assign m1 = SEC_RECIP[SEC_W-1:LIMB_W];
    assign m0 = SEC_RECIP[LIMB_W-1:0];

    assign n_c_sum = (PROD_W'(r_b_p11) << (2 * LIMB_W))
                   + ((PROD_W'(r_b_p10) + PROD_W'(r_b_p01)) << LIMB_W)
                   + PROD_W'(r_b_p00);

    assign n_e_rem = r_d_x - r_d_prod[X_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_p11  <= x1 * m1;
            r_b_p10  <= x1 * m0;
            r_b_p01  <= x0 * m1;
            r_b_p00  <= x0 * m0;
            r_b_x    <= i_x;
            r_c_q    <= n_c_sum[PROD_W-1:X_W];
            r_c_x    <= r_b_x;
            r_d_prod <= r_c_q * SEC_DIV;
            r_d_q    <= r_c_q;
            r_d_x    <= r_c_x;
            if (n_e_rem >= X_W'(SEC_DIV)) begin
                r_e_sec <= r_d_q + SEC_W'(1);
            end else begin
                r_e_sec <= r_d_q;
            end
        end
    end

    assign o_sec = r_e_sec;

endmodule

// File: src/per_second_ohlc_bar_builder.sv
// per_second_ohlc_bar_builder: top level, input stage, bar update stage and output word
// uses obb_pkg, obb_sec_div and obb_ram
//
//   channel  handshake               payload
//   in       i_in_valid/o_in_stall   i_op i_series i_timestamp_ns i_price i_quantity
//   out      o_out_valid/i_out_stall o_bar_series o_bar_second o_*_price
//
// one word per cycle while the pipe is not frozen; a word passes the input register,
// four divider stages, ram read, bar update and the out register
// one series read-modified-written per cycle unless frozen, last write forwarded to next word
// reset clears only valid, open, forward and out flags; no clearing pass, ready the cycle after reset
// the pipe freezes only while the update stage holds a word and the out word is stalled
module per_second_ohlc_bar_builder #(
    parameter int BOOK_LEVELS = obb_pkg::BOOK_LEVELS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_op,
    input  logic [obb_pkg::SERIES_W-1:0]       i_series,
    input  logic [obb_pkg::TS_W-1:0]           i_timestamp_ns,
    input  logic signed [obb_pkg::PRICE_W-1:0] i_price,
    input  logic [obb_pkg::QTY_W-1:0]          i_quantity,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [obb_pkg::SERIES_W-1:0]       o_bar_series,
    output logic [obb_pkg::SEC_W-1:0]          o_bar_second,
    output logic signed [obb_pkg::PRICE_W-1:0] o_open_price,
    output logic signed [obb_pkg::PRICE_W-1:0] o_high_price,
    output logic signed [obb_pkg::PRICE_W-1:0] o_low_price,
    output logic signed [obb_pkg::PRICE_W-1:0] o_close_price
);
    import obb_pkg::*;

    localparam int NSERIES = 2 * BOOK_LEVELS;
    localparam int AW      = $clog2(NSERIES);
    localparam int SX_W    = 6;
    localparam int E_IDX   = DIV_LAT;
    localparam int F_IDX   = DIV_LAT + 1;

    logic                 advance;
    logic [DIV_LAT+1:0]   r_vld;
    t_item                r_it [DIV_LAT+2];
    logic [X_W-1:0]       r_a_x;
    logic [SEC_W-1:0]     div_sec;
    logic [SEC_W-1:0]     r_f_sec;

    logic [NSERIES-1:0]   r_open;
    logic [AW-1:0]        e_addr;
    logic [AW-1:0]        f_addr;
    logic [BAR_W-1:0]     ram_rd;
    t_bar                 cur_bar;
    t_bar                 n_bar;
    logic                 f_open;
    logic                 f_emit;
    logic                 f_wr;
    logic                 f_set_open;
    logic                 f_clr_open;

    logic                 r_byp_v;
    logic [AW-1:0]        r_byp_addr;
    t_bar                 r_byp_bar;

    logic                 r_out_valid;
    logic [SERIES_W-1:0]  r_out_series;
    t_bar                 r_out_bar;

    t_item                n_a_item;

    assign advance    = !(r_out_valid && i_out_stall && r_vld[F_IDX]);
    assign o_in_stall = !advance;

    always_comb begin
        n_a_item.op        = i_op;
        n_a_item.series    = i_series;
        n_a_item.in_range  = SX_W'(i_series) < SX_W'(NSERIES);
        n_a_item.sample_ok = (i_price != '0) && (i_quantity != '0);
        n_a_item.price     = i_price;
    end

    // control pipe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (advance) begin
            r_vld <= {r_vld[DIV_LAT:0], i_in_valid};
        end
    end

    // payload pipe
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_it[0] <= n_a_item;
            r_a_x   <= i_timestamp_ns[TS_W-1:TS_SHIFT];
            for (int i = 1; i <= F_IDX; i++) begin
                r_it[i] <= r_it[i-1];
            end
            r_f_sec <= div_sec;
        end
    end

    obb_sec_div u_sec_div (
        .i_clk (i_clk),
        .i_en  (advance),
        .i_x   (r_a_x),
        .o_sec (div_sec)
    );

    assign e_addr = AW'(r_it[E_IDX].series);
    assign f_addr = AW'(r_it[F_IDX].series);

    obb_ram #(
        .WIDTH (BAR_W),
        .DEPTH (NSERIES)
    ) u_bar_ram (
        .i_clk     (i_clk),
        .i_wr_en   (advance && f_wr),
        .i_wr_addr (f_addr),
        .i_wr_data (n_bar),
        .i_rd_en   (advance),
        .i_rd_addr (e_addr),
        .o_rd_data (ram_rd)
    );

    // bar update
    always_comb begin
        if (r_byp_v && (r_byp_addr == f_addr)) begin
            cur_bar = r_byp_bar;
        end else begin
            cur_bar = t_bar'(ram_rd);
        end
        f_open     = r_open[f_addr];
        f_emit     = 1'b0;
        f_wr       = 1'b0;
        f_set_open = 1'b0;
        f_clr_open = 1'b0;
        n_bar      = cur_bar;
        if (r_vld[F_IDX] && r_it[F_IDX].in_range) begin
            if (r_it[F_IDX].op == OP_FLUSH) begin
                if (f_open) begin
                    f_emit     = 1'b1;
                    f_clr_open = 1'b1;
                end
            end else if (r_it[F_IDX].sample_ok) begin
                if (!f_open || (r_f_sec > cur_bar.start)) begin
                    f_emit          = f_open;
                    f_wr            = 1'b1;
                    f_set_open      = 1'b1;
                    n_bar.start     = r_f_sec;
                    n_bar.open_p    = r_it[F_IDX].price;
                    n_bar.high_p    = r_it[F_IDX].price;
                    n_bar.low_p     = r_it[F_IDX].price;
                    n_bar.close_p   = r_it[F_IDX].price;
                end else if (r_f_sec == cur_bar.start) begin
                    f_wr = 1'b1;
                    if (r_it[F_IDX].price > cur_bar.high_p) begin
                        n_bar.high_p = r_it[F_IDX].price;
                    end
                    if (r_it[F_IDX].price < cur_bar.low_p) begin
                        n_bar.low_p = r_it[F_IDX].price;
                    end
                    n_bar.close_p = r_it[F_IDX].price;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open      <= '0;
            r_byp_v     <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            if (f_set_open) begin
                r_open[f_addr] <= 1'b1;
            end else if (f_clr_open) begin
                r_open[f_addr] <= 1'b0;
            end
            r_byp_v <= f_wr;
            if (f_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_byp_addr <= f_addr;
            r_byp_bar  <= n_bar;
            if (f_emit) begin
                r_out_series <= r_it[F_IDX].series;
                r_out_bar    <= cur_bar;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_bar_series  = r_out_series;
    assign o_bar_second  = r_out_bar.start;
    assign o_open_price  = r_out_bar.open_p;
    assign o_high_price  = r_out_bar.high_p;
    assign o_low_price   = r_out_bar.low_p;
    assign o_close_price = r_out_bar.close_p;

    // an emitted bar is consistent
    a_emit_high_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        f_emit |-> (cur_bar.high_p >= cur_bar.low_p))
        else $error("emitted bar has high below low");

    a_emit_open_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        f_emit |-> (cur_bar.open_p <= cur_bar.high_p) && (cur_bar.open_p >= cur_bar.low_p)
                && (cur_bar.close_p <= cur_bar.high_p) && (cur_bar.close_p >= cur_bar.low_p))
        else $error("emitted bar has open or close outside high and low");

    // a sample only closes a bar for a later second
    a_emit_later_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (f_emit && (r_it[F_IDX].op == OP_SAMPLE)) |-> (r_f_sec > cur_bar.start))
        else $error("sample of the same or an earlier second closed a bar");

    // a result word is loaded only when the pipe moved
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(advance))
        else $error("result word appeared while the pipe was frozen");

endmodule
